[rtl/core/stable_merge_sorter_defines.svh]
// Assertion macros for the sorter RTL.
`ifndef STABLE_MERGE_SORTER_DEFINES_SVH
`define STABLE_MERGE_SORTER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define SMS_ASSERT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smsort: check failed");

// Next-cycle implication, held off while reset is asserted.
`define SMS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smsort: check failed");

`endif

[rtl/core/smsort_pkg.sv]
package smsort_pkg;

    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 16;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 16;
    localparam int REC_W  = KEY_W + PAY_W;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = CNT_W + 2;

    localparam logic [PAY_W-1:0] PAYLOAD_MASK = (PAYLOAD_BITS >= PAY_W) ?
        {PAY_W{1'b1}} : PAY_W'((64'd1 << PAYLOAD_BITS) - 64'd1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_rec;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PAIR,
        S_FETCH,
        S_CAPX,
        S_CAPY,
        S_PICK,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_OUT
    } t_state;

    // Buffer access request from the sequencer; wr_b/rd_b select buffer B.
    typedef struct packed {
        logic              wr_en;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        t_rec              wr_data;
        logic              rd_b;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    // True when the left-run record must leave before the right-run record.
    function automatic logic take_left(t_rec x, t_rec y, logic desc);
        logic le;
        logic ge;
        le = $signed(x.key) <= $signed(y.key);
        ge = $signed(x.key) >= $signed(y.key);
        return desc ? ge : le;
    endfunction

endpackage

[rtl/core/smsort_ram.sv]
module smsort_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/smsort_ctrl.sv]
`include "stable_merge_sorter_defines.svh"

module smsort_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [smsort_pkg::KEY_W-1:0]  i_key,
    input  logic [smsort_pkg::PAY_W-1:0]  i_payload,
    input  logic                          i_last_in,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_data,
    output smsort_pkg::t_mem_req          o_mem,
    input  smsort_pkg::t_rec              i_rd_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [smsort_pkg::KEY_W-1:0]  o_sorted_key,
    output logic [smsort_pkg::PAY_W-1:0]  o_sorted_payload,
    output logic                          o_last_out,
    output logic                          o_overflow
);
    import smsort_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_dropped, n_dropped;
    logic               r_desc, n_desc;
    logic               r_valid, n_valid;
    logic               r_src_b, n_src_b;
    logic               r_hx_v, n_hx_v;
    logic               r_hy_v, n_hy_v;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W:0]     r_w, n_w;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_mid, n_mid;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_x, n_x;
    logic [CNT_W-1:0]   r_y, n_y;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_i, n_i;
    t_rec               r_hx, n_hx;
    t_rec               r_hy, n_hy;
    t_rec               r_out, n_out;
    logic               r_last, n_last;
    logic               r_ovf, n_ovf;

    logic               in_acc;
    logic               full;
    logic [CNT_W-1:0]   count_inc;
    logic [SUM_W-1:0]   lo_w;
    logic [CNT_W-1:0]   mid_c;
    logic [SUM_W-1:0]   mid_w;
    logic [CNT_W-1:0]   hi_c;
    logic [CNT_W:0]     w_dbl;
    logic               pick_x;
    t_mem_req           mem;

    assign in_acc    = i_valid && !o_stall;
    assign full      = r_count >= CNT_W'(CAPACITY);
    assign count_inc = full ? r_count : r_count + 1'b1;
    assign lo_w      = SUM_W'(r_lo) + SUM_W'(r_w);
    assign mid_c     = (lo_w < SUM_W'(r_n)) ? CNT_W'(lo_w) : r_n;
    assign mid_w     = SUM_W'(mid_c) + SUM_W'(r_w);
    assign hi_c      = (mid_w < SUM_W'(r_n)) ? CNT_W'(mid_w) : r_n;
    assign w_dbl     = {r_w[CNT_W-1:0], 1'b0};
    assign pick_x    = r_hx_v && (!r_hy_v || take_left(r_hx, r_hy, r_desc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_desc    <= 1'b0;
            r_valid   <= 1'b0;
            r_src_b   <= 1'b0;
            r_hx_v    <= 1'b0;
            r_hy_v    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_desc    <= n_desc;
            r_valid   <= n_valid;
            r_src_b   <= n_src_b;
            r_hx_v    <= n_hx_v;
            r_hy_v    <= n_hy_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_w    <= n_w;
        r_lo   <= n_lo;
        r_mid  <= n_mid;
        r_hi   <= n_hi;
        r_x    <= n_x;
        r_y    <= n_y;
        r_k    <= n_k;
        r_i    <= n_i;
        r_hx   <= n_hx;
        r_hy   <= n_hy;
        r_out  <= n_out;
        r_last <= n_last;
        r_ovf  <= n_ovf;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_desc    = i_cfg_valid ? i_cfg_data : r_desc;
        n_valid   = r_valid;
        n_src_b   = r_src_b;
        n_hx_v    = r_hx_v;
        n_hy_v    = r_hy_v;
        n_n       = r_n;
        n_w       = r_w;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_x       = r_x;
        n_y       = r_y;
        n_k       = r_k;
        n_i       = r_i;
        n_hx      = r_hx;
        n_hy      = r_hy;
        n_out     = r_out;
        n_last    = r_last;
        n_ovf     = r_ovf;

        mem         = '0;
        mem.rd_b    = r_src_b;
        mem.rd_addr = r_x[ADDR_W-1:0];

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        mem.wr_en           = 1'b1;
                        mem.wr_b            = 1'b0;
                        mem.wr_addr         = r_count[ADDR_W-1:0];
                        mem.wr_data.key     = i_key;
                        mem.wr_data.payload = i_payload & PAYLOAD_MASK;
                    end
                    n_count = count_inc;
                    if (i_last_in) begin
                        n_n     = count_inc;
                        n_w     = (CNT_W+1)'(1);
                        n_lo    = '0;
                        n_i     = '0;
                        n_src_b = 1'b0;
                        n_state = (count_inc > CNT_W'(1)) ? S_PAIR : S_EMIT_RD;
                    end
                end
            end
            S_PAIR: begin
                n_mid   = mid_c;
                n_hi    = hi_c;
                n_x     = r_lo;
                n_y     = mid_c;
                n_k     = r_lo;
                n_hx_v  = 1'b0;
                n_hy_v  = 1'b0;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (!r_hx_v && (r_x < r_mid)) begin
                    mem.rd_addr = r_x[ADDR_W-1:0];
                    n_x         = r_x + 1'b1;
                    n_state     = S_CAPX;
                end else if (!r_hy_v && (r_y < r_hi)) begin
                    mem.rd_addr = r_y[ADDR_W-1:0];
                    n_y         = r_y + 1'b1;
                    n_state     = S_CAPY;
                end else if (r_hx_v || r_hy_v) begin
                    n_state = S_PICK;
                end else if (r_hi == r_n) begin
                    // pass done: swap buffers, double the run width
                    n_src_b = !r_src_b;
                    n_w     = w_dbl;
                    n_lo    = '0;
                    n_state = (w_dbl >= {1'b0, r_n}) ? S_EMIT_RD : S_PAIR;
                end else begin
                    n_lo    = r_hi;
                    n_state = S_PAIR;
                end
            end
            S_CAPX: begin
                n_hx    = i_rd_data;
                n_hx_v  = 1'b1;
                n_state = S_FETCH;
            end
            S_CAPY: begin
                n_hy    = i_rd_data;
                n_hy_v  = 1'b1;
                n_state = S_FETCH;
            end
            S_PICK: begin
                mem.wr_en   = 1'b1;
                mem.wr_b    = !r_src_b;
                mem.wr_addr = r_k[ADDR_W-1:0];
                mem.wr_data = pick_x ? r_hx : r_hy;
                n_k         = r_k + 1'b1;
                if (pick_x) begin
                    n_hx_v = 1'b0;
                end else begin
                    n_hy_v = 1'b0;
                end
                n_state = S_FETCH;
            end
            S_EMIT_RD: begin
                mem.rd_addr = r_i[ADDR_W-1:0];
                n_state     = S_EMIT_CAP;
            end
            S_EMIT_CAP: begin
                n_out   = i_rd_data;
                n_last  = ({1'b0, r_i} + 1'b1) == {1'b0, r_n};
                n_ovf   = r_dropped;
                n_valid = 1'b1;
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_stall          = (r_state != S_LOAD);
    assign o_mem            = mem;
    assign o_valid          = r_valid;
    assign o_sorted_key     = r_out.key;
    assign o_sorted_payload = r_out.payload;
    assign o_last_out       = r_last;
    assign o_overflow       = r_ovf;

    `SMS_ASSERT(a_valid_only_emit, i_clk, i_rst_n, r_valid, r_state == S_EMIT_OUT)
    `SMS_ASSERT(a_write_slot, i_clk, i_rst_n, mem.wr_en, (r_state == S_LOAD) || (r_state == S_PICK))
    `SMS_ASSERT(a_pick_in_run, i_clk, i_rst_n, r_state == S_PICK, (r_k < r_hi) && (r_hx_v || r_hy_v))
    `SMS_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SMS_ASSERT_NEXT(a_run_clears, i_clk, i_rst_n, r_valid && !i_stall && r_last, (r_state == S_LOAD) && (r_count == '0) && !r_dropped)

endmodule

[rtl/core/stable_merge_sorter.sv]
// Channel     Direction  Handshake                Payload
// input       in         i_valid / o_stall        i_key, i_payload, i_last_in
// result      out        o_valid / i_stall        o_sorted_key, o_sorted_payload,
//                                                 o_last_out, o_overflow
// config      in         i_cfg_valid / o_cfg_ready i_cfg_data (descending)
//
// Load takes one record transaction per cycle until the record marked last.
// Sort runs ceil(log2 N) merge passes; in each pass every record goes through
// read issue, capture, select and write back, with a setup and a close step per
// run pair, all set by the single read port of the source buffer.
// Emit reads, captures and presents each result transaction before it reads the next.
// Reset is synchronous active low; buffers keep their contents, counters clear.
// A stall on the result side holds the output register; input stays stalled
// from the last record until the final result transaction completes.
module stable_merge_sorter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [smsort_pkg::KEY_W-1:0]  i_key,
    input  logic [smsort_pkg::PAY_W-1:0]  i_payload,
    input  logic                          i_last_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [smsort_pkg::KEY_W-1:0]  o_sorted_key,
    output logic [smsort_pkg::PAY_W-1:0]  o_sorted_payload,
    output logic                          o_last_out,
    output logic                          o_overflow,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data
);
    import smsort_pkg::*;

    t_mem_req           mem;
    logic [REC_W-1:0]   a_rdata;
    logic [REC_W-1:0]   b_rdata;
    t_rec               rd_data;
    logic               a_we;
    logic               b_we;

    // The user must keep config writes between runs; the block does not enforce it, and o_cfg_ready stays high.
    assign o_cfg_ready = 1'b1;

    // Steer writes to the destination buffer, pick reads from the source.
    assign a_we    = mem.wr_en && !mem.wr_b;
    assign b_we    = mem.wr_en && mem.wr_b;
    assign rd_data = mem.rd_b ? t_rec'(b_rdata) : t_rec'(a_rdata);

    smsort_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_buf_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (mem.wr_addr),
        .i_wdata (mem.wr_data),
        .i_raddr (mem.rd_addr),
        .o_rdata (a_rdata)
    );

    smsort_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_buf_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (mem.wr_addr),
        .i_wdata (mem.wr_data),
        .i_raddr (mem.rd_addr),
        .o_rdata (b_rdata)
    );

    // Sequence load, merge passes and emit.
    smsort_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_key            (i_key),
        .i_payload        (i_payload),
        .i_last_in        (i_last_in),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_mem            (mem),
        .i_rd_data        (rd_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sorted_key     (o_sorted_key),
        .o_sorted_payload (o_sorted_payload),
        .o_last_out       (o_last_out),
        .o_overflow       (o_overflow)
    );

endmodule

[test/sorted_stream_checker.sv]
`timescale 1ns / 1ps
module sorted_stream_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [smsort_pkg::KEY_W-1:0]  i_key,
    input  logic [smsort_pkg::PAY_W-1:0]  i_payload,
    input  logic                          i_last_in,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [smsort_pkg::KEY_W-1:0]  o_sorted_key,
    input  logic [smsort_pkg::PAY_W-1:0]  o_sorted_payload,
    input  logic                          o_last_out,
    input  logic                          o_overflow,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked
);

    typedef struct {
        logic [smsort_pkg::KEY_W-1:0] key;
        logic [smsort_pkg::PAY_W-1:0] payload;
        logic                         last_out;
        logic                         overflow;
    } t_sorted_rec;

    smsort_pkg::t_rec loaded_records[$];
    smsort_pkg::t_rec ordered[$];
    t_sorted_rec      pending_sorted[$];
    logic             descending;
    logic             dropped;
    int               errors  = 0;
    int               checked = 0;

    assign o_errors  = errors;
    assign o_pending = pending_sorted.size();
    assign o_checked = checked;

    always @(posedge i_clk) begin
        smsort_pkg::t_rec rec;
        t_sorted_rec      want;
        int               pos;
        if (!i_rst_n) begin
            loaded_records.delete();
            pending_sorted.delete();
            descending = 1'b0;
            dropped    = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                descending = i_cfg_data;
            end

            if (i_valid && !o_stall) begin
                if (loaded_records.size() < smsort_pkg::CAPACITY) begin
                    rec.key     = i_key;
                    rec.payload = i_payload & smsort_pkg::PAYLOAD_MASK;
                    loaded_records.push_back(rec);
                end else begin
                    dropped = 1'b1;
                end
                if (i_last_in) begin
                    // insert each record behind every earlier one it may not pass,
                    // so equal keys keep arrival order
                    ordered.delete();
                    foreach (loaded_records[i]) begin
                        rec = loaded_records[i];
                        pos = ordered.size();
                        while (pos > 0 && (descending ?
                               $signed(ordered[pos-1].key) < $signed(rec.key) :
                               $signed(ordered[pos-1].key) > $signed(rec.key))) begin
                            pos--;
                        end
                        ordered.insert(pos, rec);
                    end
                    foreach (ordered[i]) begin
                        want.key      = ordered[i].key;
                        want.payload  = ordered[i].payload;
                        want.last_out = (i == ordered.size() - 1);
                        want.overflow = dropped;
                        pending_sorted.push_back(want);
                    end
                    loaded_records.delete();
                    dropped = 1'b0;
                end
            end

            if (o_valid && !i_stall) begin
                checked++;
                if (pending_sorted.size() == 0) begin
                    $error("sorted record with none pending: key %0d payload %0h",
                           $signed(o_sorted_key), o_sorted_payload);
                    errors++;
                end else begin
                    want = pending_sorted.pop_front();
                    if (o_sorted_key !== want.key) begin
                        $error("sorted_key: expected %0d, actual %0d",
                               $signed(want.key), $signed(o_sorted_key));
                        errors++;
                    end
                    if (o_sorted_payload !== want.payload) begin
                        $error("sorted_payload: expected %0h, actual %0h",
                               want.payload, o_sorted_payload);
                        errors++;
                    end
                    if (o_last_out !== want.last_out) begin
                        $error("last_out: expected %0b, actual %0b",
                               want.last_out, o_last_out);
                        errors++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, o_overflow);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

    // Stop feeding new lists once this many records have gone in.
    localparam int RECORD_TARGET = 220;
    // Worst case is far below this: random gaps before each record, random stalls
    // after each result, the emit steps and every merge pass.
    localparam int CYCLE_LIMIT   = 400000;
    // Idle time before a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 16;
    localparam int FINAL_CYCLES  = 60;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [smsort_pkg::KEY_W-1:0]  i_key;
    logic [smsort_pkg::PAY_W-1:0]  i_payload;
    logic                          i_last_in;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [smsort_pkg::KEY_W-1:0]  o_sorted_key;
    logic [smsort_pkg::PAY_W-1:0]  o_sorted_payload;
    logic                          o_last_out;
    logic                          o_overflow;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic                          i_cfg_data;

    int   errors;
    int   pending;
    int   checked;

    // Idle control: a calm side never inserts gaps or stalls.
    bit   tx_calm = 1'b1;
    bit   rx_calm = 1'b1;
    int   stall_left = 0;
    int   cycles = 0;
    int   records_sent = 0;
    int   lists_sent = 0;
    int   overflow_lists = 0;
    bit   saw_ascending = 1'b0;
    bit   saw_descending = 1'b0;

    // Directed list: both key extremes, zero, minus one, and a repeated key
    // to show that equal keys keep their arrival order.
    logic [31:0] dir_key [6] = '{32'd7, 32'h8000_0000, 32'd7,
                                 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0};
    logic [15:0] dir_pay [6] = '{16'h0001, 16'hFFFF, 16'h0002,
                                 16'h0000, 16'h8000, 16'h7FFF};

    stable_merge_sorter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_key            (i_key),
        .i_payload        (i_payload),
        .i_last_in        (i_last_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sorted_key     (o_sorted_key),
        .o_sorted_payload (o_sorted_payload),
        .o_last_out       (o_last_out),
        .o_overflow       (o_overflow),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    sorted_stream_checker u_sort_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_key            (i_key),
        .i_payload        (i_payload),
        .i_last_in        (i_last_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sorted_key     (o_sorted_key),
        .o_sorted_payload (o_sorted_payload),
        .o_last_out       (o_last_out),
        .o_overflow       (o_overflow),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d sorted records still owed", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: after each result transaction draw a random stall length.
    // Also start stalls now and then while nothing is offered, so a stall can
    // already be up when the first record of a list appears.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
        end else if (o_valid && !i_stall) begin
            stall_left = rx_calm ? 0 : $urandom_range(0, 19);
        end else if (stall_left != 0) begin
            stall_left--;
        end else if (!rx_calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        i_stall <= (stall_left != 0);
    end

    // Offer one record; return at the edge where the transaction completes.
    // Hold the payload steady while the sorter stalls.
    task automatic send_record(input logic [31:0] key, input logic [15:0] payload,
                               input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_key     <= key;
        i_payload <= payload;
        i_last_in <= last;
        do @(posedge i_clk); while (o_stall);
        records_sent++;
        if (last) begin
            lists_sent++;
        end
    endtask

    // Mix of key extremes, a narrow band around zero that forces many equal
    // keys, and full-range random keys.
    function automatic logic [31:0] pick_key();
        int band;
        band = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return 32'(band);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_list(input int n_records);
        if (n_records > smsort_pkg::CAPACITY) begin
            overflow_lists++;
        end
        for (int i = 0; i < n_records; i++) begin
            send_record(pick_key(), 16'($urandom()), i == n_records - 1);
        end
    endtask

    // Drop valid and wait until every owed result has arrived, then let the
    // sorter settle. Sample the count mid-cycle, away from the clock edge.
    task automatic drain(input int settle);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write the sort direction; only call while the sorter is idle.
    task automatic write_order(input logic descending);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= descending;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (descending) begin
            saw_descending = 1'b1;
        end else begin
            saw_ascending = 1'b1;
        end
    endtask

    initial begin
        int n;
        int round;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_key       <= '0;
        i_payload   <= '0;
        i_last_in   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ascending, a single-record list at the minimum key, then the directed list.
        write_order(1'b0);
        send_record(32'h8000_0000, 16'hFFFF, 1'b1);
        for (int i = 0; i < 6; i++) begin
            send_record(dir_key[i], dir_pay[i], i == 5);
        end
        drain(SETTLE_CYCLES);

        // Same list descending, now with gaps and stalls on both sides.
        write_order(1'b1);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        for (int i = 0; i < 6; i++) begin
            send_record(dir_key[i], dir_pay[i], i == 5);
        end
        // Equal maximum keys must leave in arrival order when descending too.
        send_record(32'h7FFF_FFFF, 16'h0000, 1'b0);
        send_record(32'h7FFF_FFFF, 16'h0001, 1'b0);
        send_record(32'h8000_0000, 16'h0002, 1'b1);
        drain(SETTLE_CYCLES);

        // Random lists: mostly short, one exactly at capacity, one past it so
        // the marked record itself is dropped.
        round = 0;
        while (records_sent < RECORD_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                drain(SETTLE_CYCLES);
                write_order(1'($urandom_range(0, 1)));
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (round == 2) begin
                n = smsort_pkg::CAPACITY;
            end else if (round == 5) begin
                n = smsort_pkg::CAPACITY + 1 + $urandom_range(0, 3);
            end else if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 2);
            end else begin
                n = $urandom_range(3, 12);
            end
            send_list(n);
            round++;
        end

        drain(FINAL_CYCLES);
        $display("Sorted %0d lists from %0d records, %0d of them past capacity",
                 lists_sent, records_sent, overflow_lists);
        $display("Checked %0d result transactions; ascending %0b, descending %0b",
                 checked, saw_ascending, saw_descending);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
